/* src/swsax_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swsax_pkg
// Shared constants, widths and transfer types of the sliding-window SAX
// encoder.
// ---------------------------------------------------------------------------
package swsax_pkg;

  localparam int MAX_WINDOW   = 256;
  localparam int MAX_SEGMENTS = 15;
  localparam int SAMPLE_BITS  = 16;

  localparam int ID_W      = 16;
  localparam int POS_W     = 16;
  localparam int WORD_W    = 2 * MAX_SEGMENTS;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int SEGS_W    = 4;

  localparam int N_W     = $clog2(MAX_WINDOW + 1);
  localparam int RING_AW = $clog2(MAX_WINDOW);
  localparam int SEG_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int SEG_IW  = $clog2(MAX_SEGMENTS);
  localparam int SUM_W   = SAMPLE_BITS + RING_AW;
  localparam int SQ_W    = 2 * SAMPLE_BITS + RING_AW;
  localparam int NQ_W    = SQ_W + N_W;
  localparam int V_W     = 2 * SUM_W;
  localparam int D_W     = SUM_W + N_W + 1;
  localparam int START_W = $clog2(MAX_SEGMENTS * (2 ** CFG_W));
  localparam int C2_W    = 2 * N_W;

  localparam int MUL_W     = 48;
  localparam int CHUNK_W   = 16;
  localparam int MUL_STEPS = MUL_W / CHUNK_W;
  localparam int STEP_W    = $clog2(MUL_STEPS);
  localparam int PROD_W    = 2 * MUL_W;
  localparam int CMP_W     = PROD_W + 32;

  localparam int FIFO_DEPTH = 2;

  // 0.67 in Q16 is 43909; its square in Q32
  localparam int THR_W = 31;
  localparam logic [THR_W-1:0] THR_SQ = 31'd1928000281;

  localparam logic [POS_W-1:0] MAX_POS = {POS_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_SEGMENTS  = 2'd2;

  localparam logic [CFG_W-1:0]  RST_WINDOW_LEN    = 9'd60;
  localparam logic [CFG_W-1:0]  RST_SEGMENT_WIDTH = 9'd4;
  localparam logic [SEGS_W-1:0] RST_NUM_SEGMENTS  = 4'd15;

  typedef logic [1:0] sym_t;

  // symbol codes, lowest band to highest
  localparam sym_t SYM_BELOW = 2'd0;
  localparam sym_t SYM_NEG   = 2'd1;
  localparam sym_t SYM_POS   = 2'd2;
  localparam sym_t SYM_ABOVE = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          emit;
    logic [ID_W-1:0]               series;
    logic [POS_W-1:0]              wstart;
    logic [N_W-1:0]                n;
    logic [CFG_W-1:0]              w;
    logic [SEG_W-1:0]              segs;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

endpackage
`default_nettype wire

/* src/swsax_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swsax_if
// Valid/ready channels for samples in and SAX words out.
// ---------------------------------------------------------------------------
interface swsax_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [swsax_pkg::SAMPLE_BITS-1:0] sample;
  logic [swsax_pkg::ID_W-1:0]               series_id;
  logic                                    series_start;

  modport source (output valid, output sample, output series_id, output series_start,
                  input ready);
  modport sink (input valid, input sample, input series_id, input series_start,
                output ready);
endinterface

interface swsax_out_if;
  logic                              valid;
  logic                              ready;
  logic [swsax_pkg::WORD_W-1:0]       sax_word;
  logic [swsax_pkg::ID_W-1:0]         word_series;
  logic [swsax_pkg::POS_W-1:0]        window_start;

  modport source (output valid, output sax_word, output word_series, output window_start,
                  input ready);
  modport sink (input valid, input sax_word, input word_series, input window_start,
                output ready);
endinterface
`default_nettype wire

/* src/sliding_window_sax_encoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sliding_window_sax_encoder
// Sliding-window SAX encoder: one 2-bit symbol per segment of every full
// window, word packed first segment in the highest bits.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  samples   in   valid/ready    sample, series_id, series_start
//  words     out  valid/ready    sax_word, word_series, window_start
//  cfg       in   cfg_we         cfg_index, cfg_data (write only)
//
//  A sample that completes no window is written to the ring without leaving
//  the idle state. A sample that completes one is followed by a scan of the
//  ring memory through its single read port, the two variance states, then
//  per segment two setup states and two rounds of the wide multiplier, each
//  of three digit steps and the done cycle.
//  The front keeps taking samples into a two-entry job queue while the back
//  works; a finished word waits in the output register, and the back stalls
//  only when the next word is ready before that one has left.
//  Reset is synchronous; the ring needs no clearing pass since it is only
//  read where it has been written.
//
module sliding_window_sax_encoder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  swsax_in_if.sink                             samples,
  swsax_out_if.source                          words,
  input  wire logic                            cfg_we,
  input  wire logic [swsax_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [swsax_pkg::CFG_W-1:0]     cfg_data
);

  // front -> queue
  logic                  push;
  swsax_pkg::job_t       push_job;
  // queue -> back
  logic                  pop;
  swsax_pkg::job_t       head_job;
  swsax_pkg::fifo_stat_t stat;
  // back <-> multiplier
  swsax_pkg::mul_req_t   mul_req;
  swsax_pkg::mul_rsp_t   mul_rsp;

  // position, fill and window decision per sample transaction
  swsax_front u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .push      (push),
    .job       (push_job)
  );

  swsax_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_job),
    .pop   (pop),
    .rdata (head_job),
    .stat  (stat)
  );

  // ring write, window sums, symbol quantizing
  swsax_back u_back (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .head_job (head_job),
    .pop      (pop),
    .mul_req  (mul_req),
    .mul_rsp  (mul_rsp),
    .words    (words)
  );

  swsax_mult u_mult (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // the back never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("job popped from empty queue");

  // a pushed job is visible to the back on the next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    push |=> !stat.empty)
    else $error("pushed job lost");

  // a product is never ready right after its start; no stale done either
  a_mult_latency: assert property (@(posedge clk) disable iff (rst)
    mul_req.start |=> !mul_rsp.done)
    else $error("multiplier done too early");

endmodule
`default_nettype wire

/* src/swsax_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swsax_front
// Accepts samples, tracks series position and fill, holds the configuration
// and decides whether a sample completes a window.
// ---------------------------------------------------------------------------
module swsax_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  swsax_in_if.sink                             samples,
  input  wire logic                            cfg_we,
  input  wire logic [swsax_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [swsax_pkg::CFG_W-1:0]     cfg_data,
  input  wire swsax_pkg::fifo_stat_t           stat,
  output logic                                 push,
  output swsax_pkg::job_t                      job
);

  logic [swsax_pkg::CFG_W-1:0]  window_len;
  logic [swsax_pkg::CFG_W-1:0]  segment_width;
  logic [swsax_pkg::SEGS_W-1:0] num_segments;
  logic [swsax_pkg::N_W-1:0]    fill_count;
  logic [swsax_pkg::POS_W-1:0]  position;
  logic [swsax_pkg::ID_W-1:0]   current_series;

  logic [swsax_pkg::N_W-1:0]    fill_base, fill_count_next;
  logic [swsax_pkg::POS_W-1:0]  idx, position_next;
  logic [swsax_pkg::ID_W-1:0]   current_series_next;
  logic [swsax_pkg::N_W-1:0]    n;
  logic [swsax_pkg::CFG_W-1:0]  w;
  logic [swsax_pkg::SEG_W-1:0]  segs;

  assign samples.ready = !stat.full;
  assign push = samples.valid && samples.ready;

  always_comb begin
    idx = samples.series_start ? '0 : position;
    fill_base = samples.series_start ? '0 : fill_count;
    fill_count_next = (fill_base < swsax_pkg::N_W'(swsax_pkg::MAX_WINDOW)) ?
                      fill_base + 1'b1 : fill_base;
    position_next = (idx != swsax_pkg::MAX_POS) ? idx + 1'b1 : idx;
    current_series_next = samples.series_start ? samples.series_id : current_series;

    // clamp registers to the legal geometry
    if (window_len < swsax_pkg::CFG_W'(2)) begin
      n = swsax_pkg::N_W'(2);
    end else if (window_len > swsax_pkg::CFG_W'(swsax_pkg::MAX_WINDOW)) begin
      n = swsax_pkg::N_W'(swsax_pkg::MAX_WINDOW);
    end else begin
      n = swsax_pkg::N_W'(window_len);
    end
    w = (segment_width == '0) ? swsax_pkg::CFG_W'(1) : segment_width;
    if (num_segments == '0) begin
      segs = swsax_pkg::SEG_W'(1);
    end else if (num_segments > swsax_pkg::SEGS_W'(swsax_pkg::MAX_SEGMENTS)) begin
      segs = swsax_pkg::SEG_W'(swsax_pkg::MAX_SEGMENTS);
    end else begin
      segs = swsax_pkg::SEG_W'(num_segments);
    end

    job.sample = samples.sample;
    job.emit   = (fill_count_next >= n);
    job.series = current_series_next;
    job.wstart = (idx == swsax_pkg::MAX_POS) ? swsax_pkg::MAX_POS :
                 swsax_pkg::POS_W'(idx + 1'b1 - swsax_pkg::POS_W'(n));
    job.n      = n;
    job.w      = w;
    job.segs   = segs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len     <= swsax_pkg::RST_WINDOW_LEN;
      segment_width  <= swsax_pkg::RST_SEGMENT_WIDTH;
      num_segments   <= swsax_pkg::RST_NUM_SEGMENTS;
      fill_count     <= '0;
      position       <= '0;
      current_series <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          swsax_pkg::REG_WINDOW_LEN:    window_len <= cfg_data;
          swsax_pkg::REG_SEGMENT_WIDTH: segment_width <= cfg_data;
          swsax_pkg::REG_NUM_SEGMENTS:  num_segments <= cfg_data[swsax_pkg::SEGS_W-1:0];
          default: ;
        endcase
      end
      if (push) begin
        fill_count     <= fill_count_next;
        position       <= position_next;
        current_series <= current_series_next;
      end
    end
  end

endmodule
`default_nettype wire

/* src/swsax_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swsax_fifo
// Short job queue between the front and the back.
// ---------------------------------------------------------------------------
module swsax_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire swsax_pkg::job_t  wdata,
  input  wire logic             pop,
  output swsax_pkg::job_t       rdata,
  output swsax_pkg::fifo_stat_t stat
);

  localparam int PTR_W = (swsax_pkg::FIFO_DEPTH > 1) ? $clog2(swsax_pkg::FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(swsax_pkg::FIFO_DEPTH + 1);

  swsax_pkg::job_t    mem [swsax_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]   wptr, rptr;
  logic [CNT_W-1:0]   count;

  assign rdata = mem[rptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(swsax_pkg::FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(swsax_pkg::FIFO_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(swsax_pkg::FIFO_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* src/swsax_mult.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swsax_mult
// Wide unsigned multiplier, one 16-bit digit of b per cycle.
// ---------------------------------------------------------------------------
module swsax_mult (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire swsax_pkg::mul_req_t req,
  output swsax_pkg::mul_rsp_t      rsp
);

  logic [swsax_pkg::MUL_W-1:0]                     a_r, b_r;
  logic [swsax_pkg::PROD_W-1:0]                    acc;
  logic [swsax_pkg::STEP_W-1:0]                    step;
  logic                                            busy, done;
  logic [swsax_pkg::CHUNK_W-1:0]                   chunk;
  logic [swsax_pkg::MUL_W+swsax_pkg::CHUNK_W-1:0]  pp;
  logic [swsax_pkg::PROD_W-1:0]                    addend;

  always_comb begin
    chunk  = b_r[step*swsax_pkg::CHUNK_W +: swsax_pkg::CHUNK_W];
    pp     = a_r * chunk;
    addend = swsax_pkg::PROD_W'(pp) << (step * swsax_pkg::CHUNK_W);
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == swsax_pkg::STEP_W'(swsax_pkg::MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          step <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
      acc <= '0;
    end else if (busy) begin
      acc <= acc + addend;
    end
  end

endmodule
`default_nettype wire

/* src/swsax_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swsax_back
// Sample ring, window scan for sums, variance and per-segment quantizing,
// output register.
// ---------------------------------------------------------------------------
module swsax_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire swsax_pkg::fifo_stat_t stat,
  input  wire swsax_pkg::job_t       head_job,
  output logic                       pop,
  output swsax_pkg::mul_req_t        mul_req,
  input  wire swsax_pkg::mul_rsp_t   mul_rsp,
  swsax_out_if.source                words
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_VAR1 = 4'd2;
  localparam logic [3:0] S_VAR2 = 4'd3;
  localparam logic [3:0] S_SEG  = 4'd4;
  localparam logic [3:0] S_DIFF = 4'd5;
  localparam logic [3:0] S_MULL = 4'd6;
  localparam logic [3:0] S_MULR = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state;

  // sample ring
  logic signed [swsax_pkg::SAMPLE_BITS-1:0] ring [swsax_pkg::MAX_WINDOW];
  logic signed [swsax_pkg::SAMPLE_BITS-1:0] q;
  logic [swsax_pkg::RING_AW-1:0]            head, rd_addr;
  logic                                     rd_en;

  swsax_pkg::job_t job_r;

  // scan
  logic [swsax_pkg::N_W-1:0]                iss_cnt, in_i;
  logic [swsax_pkg::SEG_IW-1:0]             seg_i, seg1;
  logic                                     v1, v2;
  logic signed [2*swsax_pkg::SAMPLE_BITS-1:0] sq_c;
  logic [2*swsax_pkg::SAMPLE_BITS-1:0]      sq;
  logic signed [swsax_pkg::SUM_W-1:0]       sum;
  logic [swsax_pkg::SQ_W-1:0]               sqsum;
  logic signed [swsax_pkg::SUM_W-1:0]       segsum [swsax_pkg::MAX_SEGMENTS];

  // variance and segments
  logic [swsax_pkg::NQ_W-1:0]               nq;
  logic signed [swsax_pkg::V_W-1:0]         ss;
  logic [swsax_pkg::V_W-1:0]                vnum;
  logic [swsax_pkg::SEG_IW-1:0]             k;
  logic [swsax_pkg::START_W-1:0]            start;
  logic                                     start_ge, last;
  logic [swsax_pkg::N_W-1:0]                rem_c, cnt_c, cnt_r;
  logic signed [swsax_pkg::D_W-1:0]         ds1, ds2, d_c;
  logic [swsax_pkg::D_W-1:0]                mag_c;
  logic [swsax_pkg::C2_W-1:0]               c2;
  logic [swsax_pkg::THR_W+swsax_pkg::C2_W-1:0] f_full;
  logic [swsax_pkg::MUL_W-1:0]              f;
  logic                                     dneg;
  logic [swsax_pkg::PROD_W-1:0]             lsq;
  logic [swsax_pkg::CMP_W-1:0]              lhs, rhs;
  swsax_pkg::sym_t                          sym;
  logic [swsax_pkg::WORD_W-1:0]             word;

  // output register
  logic                         out_valid;
  logic [swsax_pkg::WORD_W-1:0] out_word;
  logic [swsax_pkg::ID_W-1:0]   out_series;
  logic [swsax_pkg::POS_W-1:0]  out_wstart;
  logic                         out_fire;

  assign pop   = (state == S_IDLE) && !stat.empty;
  assign rd_en = (state == S_SCAN) && (iss_cnt != job_r.n);
  assign rd_addr = head - job_r.n[swsax_pkg::RING_AW-1:0] +
                   iss_cnt[swsax_pkg::RING_AW-1:0];
  assign out_fire = (state == S_OUT) && (!out_valid || words.ready);

  assign words.valid        = out_valid;
  assign words.sax_word     = out_word;
  assign words.word_series  = out_series;
  assign words.window_start = out_wstart;

  always_comb begin
    sq_c = q * q;

    start_ge = (start >= swsax_pkg::START_W'(job_r.n));
    last     = (k == swsax_pkg::SEG_IW'(job_r.segs - 1'b1));
    rem_c    = swsax_pkg::N_W'(swsax_pkg::START_W'(job_r.n) - start);
    if (start_ge) begin
      cnt_c = '0;
    end else if (last) begin
      cnt_c = rem_c;
    end else if (swsax_pkg::CFG_W'(rem_c) < job_r.w) begin
      cnt_c = rem_c;
    end else begin
      cnt_c = swsax_pkg::N_W'(job_r.w);
    end

    d_c    = ds1 - ds2;
    mag_c  = d_c[swsax_pkg::D_W-1] ? -d_c : d_c;
    f_full = swsax_pkg::THR_SQ * c2;

    mul_req.start = (state == S_DIFF) || ((state == S_MULL) && mul_rsp.done);
    if (state == S_DIFF) begin
      mul_req.a = swsax_pkg::MUL_W'(mag_c);
      mul_req.b = swsax_pkg::MUL_W'(mag_c);
    end else begin
      mul_req.a = f;
      mul_req.b = swsax_pkg::MUL_W'(vnum);
    end

    // |d| against 0.67: D*D*2^32 versus t*t*c*c*V
    lhs = {lsq, 32'b0};
    rhs = swsax_pkg::CMP_W'(mul_rsp.prod);
    if ((cnt_r == '0) || (vnum == '0)) begin
      sym = swsax_pkg::SYM_ABOVE;
    end else if (dneg) begin
      sym = (lhs > rhs) ? swsax_pkg::SYM_BELOW : swsax_pkg::SYM_NEG;
    end else begin
      sym = (lhs < rhs) ? swsax_pkg::SYM_POS : swsax_pkg::SYM_ABOVE;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ring[head] <= head_job.sample;
    end
    if (rd_en) begin
      q <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= rd_en;
      v2 <= v1;
      if (out_valid && words.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            head <= head + 1'b1;
            if (head_job.emit) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if ((iss_cnt == job_r.n) && !v1 && !v2) begin
            state <= S_VAR1;
          end
        end
        S_VAR1: state <= S_VAR2;
        S_VAR2: state <= S_SEG;
        S_SEG:  state <= S_DIFF;
        S_DIFF: state <= S_MULL;
        S_MULL: begin
          if (mul_rsp.done) begin
            state <= S_MULR;
          end
        end
        S_MULR: begin
          if (mul_rsp.done) begin
            state <= last ? S_OUT : S_SEG;
          end
        end
        S_OUT: begin
          if (out_fire) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r   <= head_job;
      iss_cnt <= '0;
      seg_i   <= '0;
      in_i    <= '0;
      sum     <= '0;
      sqsum   <= '0;
      for (int i = 0; i < swsax_pkg::MAX_SEGMENTS; i++) begin
        segsum[i] <= '0;
      end
    end
    if (rd_en) begin
      iss_cnt <= iss_cnt + 1'b1;
      seg1    <= seg_i;
      if ((in_i == swsax_pkg::N_W'(job_r.w - 1'b1)) &&
          (seg_i != swsax_pkg::SEG_IW'(job_r.segs - 1'b1))) begin
        seg_i <= seg_i + 1'b1;
        in_i  <= '0;
      end else begin
        in_i <= in_i + 1'b1;
      end
    end
    if (v1) begin
      sum          <= sum + swsax_pkg::SUM_W'(q);
      segsum[seg1] <= segsum[seg1] + swsax_pkg::SUM_W'(q);
      sq           <= sq_c;
    end
    if (v2) begin
      sqsum <= sqsum + swsax_pkg::SQ_W'(sq);
    end
    case (state)
      S_VAR1: begin
        nq <= job_r.n * sqsum;
        ss <= sum * sum;
      end
      S_VAR2: begin
        vnum  <= swsax_pkg::V_W'(nq) - $unsigned(ss);
        k     <= '0;
        start <= '0;
        word  <= '0;
      end
      S_SEG: begin
        cnt_r <= cnt_c;
        ds1   <= segsum[k] * $signed({1'b0, job_r.n});
        ds2   <= sum * $signed({1'b0, cnt_c});
        c2    <= cnt_c * cnt_c;
      end
      S_DIFF: begin
        dneg <= d_c[swsax_pkg::D_W-1];
        f    <= f_full[swsax_pkg::MUL_W-1:0];
      end
      S_MULL: begin
        if (mul_rsp.done) begin
          lsq <= mul_rsp.prod;
        end
      end
      S_MULR: begin
        if (mul_rsp.done) begin
          word  <= {word[swsax_pkg::WORD_W-3:0], sym};
          k     <= k + 1'b1;
          start <= start + swsax_pkg::START_W'(job_r.w);
        end
      end
      S_OUT: begin
        if (out_fire) begin
          out_word   <= word;
          out_series <= job_r.series;
          out_wstart <= job_r.wstart;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* sim/sliding_window_sax_encoder_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sliding_window_sax_encoder_tb
// Self-checking bench for the sliding-window SAX encoder. Samples are pushed
// through the input channel while a bit-exact window predictor in the bench
// builds the expected SAX words. Every word that leaves the block is checked
// field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module sliding_window_sax_encoder_tb;

  localparam int DRAIN_CYCLES = 700;  // worst window plus margin

  typedef struct {
    logic [swsax_pkg::WORD_W-1:0] word;
    logic [swsax_pkg::ID_W-1:0]   series;
    logic [swsax_pkg::POS_W-1:0]  wstart;
  } sax_word_t;

  logic clk = 1'b0;
  logic rst;
  logic                            cfg_we;
  logic [swsax_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [swsax_pkg::CFG_W-1:0]     cfg_data;

  swsax_in_if  samples_ch ();
  swsax_out_if words_ch ();

  sliding_window_sax_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_ch),
    .words     (words_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Window predictor: shadow of the ring, counters and registers
  // -------------------------------------------------------------------------
  logic signed [swsax_pkg::SAMPLE_BITS-1:0] ring_shadow [swsax_pkg::MAX_WINDOW];
  int unsigned ring_wr;
  int unsigned fill_shadow;
  int unsigned pos_shadow;
  logic [swsax_pkg::ID_W-1:0] series_shadow;
  int unsigned win_len_reg, seg_width_reg, num_segs_reg;

  sax_word_t pending_words[$];

  int unsigned n_sent, n_words, n_errors;
  int unsigned n_zero_var;

  // Quantize one segment against +/-0.67 without a root: compare squares.
  function automatic swsax_pkg::sym_t segment_symbol(longint seg_sum, int unsigned cnt,
                                                     int unsigned n, longint win_sum,
                                                     longint var_num);
    longint      dev;
    logic [127:0] mag, lhs, rhs;
    if (cnt == 0 || var_num == 0) return swsax_pkg::SYM_ABOVE;
    dev = seg_sum * longint'(n) - win_sum * longint'(cnt);
    mag = (dev < 0) ? 128'(-dev) : 128'(dev);
    lhs = (mag * mag) << 32;
    rhs = 128'(swsax_pkg::THR_SQ) * 128'(cnt) * 128'(cnt) * 128'(var_num);
    if (dev < 0) return (lhs > rhs) ? swsax_pkg::SYM_BELOW : swsax_pkg::SYM_NEG;
    return (lhs < rhs) ? swsax_pkg::SYM_POS : swsax_pkg::SYM_ABOVE;
  endfunction

  // Accepted sample -> update shadow state, queue a word if the window is full.
  function automatic void predict_window(logic [swsax_pkg::SAMPLE_BITS-1:0] smp,
                                         logic [swsax_pkg::ID_W-1:0] id, logic first);
    int unsigned idx, n, w, segs, base, seg, start, cnt;
    longint      win_sum, sq_sum, v, var_num;
    longint      seg_sum [swsax_pkg::MAX_SEGMENTS];
    logic [swsax_pkg::WORD_W-1:0] word;
    sax_word_t   res;
    if (first) begin
      fill_shadow   = 0;
      pos_shadow    = 0;
      series_shadow = id;
    end
    idx = pos_shadow;
    if (pos_shadow < 65535) pos_shadow++;
    ring_shadow[ring_wr] = smp;
    ring_wr = (ring_wr + 1) % swsax_pkg::MAX_WINDOW;
    if (fill_shadow < swsax_pkg::MAX_WINDOW) fill_shadow++;

    // out-of-range register values are clamped
    n    = (win_len_reg < 2) ? 2 : ((win_len_reg > swsax_pkg::MAX_WINDOW) ?
                                    swsax_pkg::MAX_WINDOW : win_len_reg);
    w    = (seg_width_reg < 1) ? 1 : seg_width_reg;
    segs = (num_segs_reg < 1) ? 1 : ((num_segs_reg > swsax_pkg::MAX_SEGMENTS) ?
                                     swsax_pkg::MAX_SEGMENTS : num_segs_reg);
    if (fill_shadow < n) return;

    base = ring_wr + swsax_pkg::MAX_WINDOW - n;
    win_sum = 0;
    sq_sum  = 0;
    foreach (seg_sum[k]) seg_sum[k] = 0;
    for (int j = 0; j < n; j++) begin
      v = longint'(ring_shadow[(base + j) % swsax_pkg::MAX_WINDOW]);
      seg = j / w;
      if (seg >= segs) seg = segs - 1;  // last segment soaks up the remainder
      win_sum += v;
      sq_sum  += v * v;
      seg_sum[seg] += v;
    end
    var_num = longint'(n) * sq_sum - win_sum * win_sum;
    if (var_num == 0) n_zero_var++;

    word = '0;
    for (int k = 0; k < segs; k++) begin
      start = k * w;
      if (start >= n) cnt = 0;           // empty segment
      else if (k + 1 == segs) cnt = n - start;
      else cnt = (n - start < w) ? n - start : w;
      word = (word << 2) |
             swsax_pkg::WORD_W'(segment_symbol(seg_sum[k], cnt, n, win_sum, var_num));
    end
    res.word   = word;
    res.series = series_shadow;
    res.wstart = (idx >= 65535) ? swsax_pkg::MAX_POS : swsax_pkg::POS_W'(idx + 1 - n);
    pending_words.push_back(res);
  endfunction

  // -------------------------------------------------------------------------
  // Word checker: every output transaction against the oldest prediction
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    sax_word_t exp_w;
    if (!rst && words_ch.valid && words_ch.ready) begin
      n_words++;
      if (pending_words.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("[%0t] unexpected word %h series %h start %0d", $time,
                   words_ch.sax_word, words_ch.word_series, words_ch.window_start);
      end else begin
        exp_w = pending_words.pop_front();
        if (words_ch.sax_word !== exp_w.word || words_ch.word_series !== exp_w.series ||
            words_ch.window_start !== exp_w.wstart) begin
          n_errors++;
          if (n_errors <= 10)
            $display("[%0t] word mismatch: exp %h/%h/%0d got %h/%h/%0d", $time,
                     exp_w.word, exp_w.series, exp_w.wstart, words_ch.sax_word,
                     words_ch.word_series, words_ch.window_start);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: random stall pattern, plus a long hold-off counted here
  // -------------------------------------------------------------------------
  int unsigned stall_pct;    // chance of a stall cycle, per phase
  int unsigned hold_cycles;  // long hold-off requested by a test

  always @(posedge clk) begin
    if (rst) begin
      words_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      words_ch.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      words_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps
  // -------------------------------------------------------------------------
  int unsigned gap_max;
  int unsigned burst_left;

  // Called right after a rising edge; returns right after the edge that
  // accepted the transaction, with valid still high.
  task automatic send_sample(logic [swsax_pkg::SAMPLE_BITS-1:0] smp,
                             logic [swsax_pkg::ID_W-1:0] id, logic first);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        samples_ch.valid <= 1'b0;
        repeat ($urandom_range(gap_max, 1)) @(posedge clk);
      end
      burst_left = $urandom_range(12, 1);
    end
    burst_left--;
    samples_ch.valid        <= 1'b1;
    samples_ch.sample       <= smp;
    samples_ch.series_id    <= id;
    samples_ch.series_start <= first;
    do @(negedge clk); while (!samples_ch.ready);
    @(posedge clk);
    predict_window(smp, id, first);
    n_sent++;
  endtask

  // Let all predicted words arrive, then give the back end time to finish.
  task automatic drain_words();
    samples_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the enable drops for a cycle before the next write.
  task automatic write_reg(logic [swsax_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= swsax_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      swsax_pkg::REG_WINDOW_LEN:    win_len_reg   = val & 9'h1FF;
      swsax_pkg::REG_SEGMENT_WIDTH: seg_width_reg = val & 9'h1FF;
      swsax_pkg::REG_NUM_SEGMENTS:  num_segs_reg  = val & 4'hF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_geometry(int unsigned n, int unsigned w, int unsigned segs);
    write_reg(swsax_pkg::REG_WINDOW_LEN, n);
    write_reg(swsax_pkg::REG_SEGMENT_WIDTH, w);
    write_reg(swsax_pkg::REG_NUM_SEGMENTS, segs);
  endtask

  // Half ordinary values, the rest extremes, tiny values and flat runs.
  logic [swsax_pkg::SAMPLE_BITS-1:0] last_smp;
  function automatic logic [swsax_pkg::SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(5))
      0: last_smp = ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
      1: last_smp = swsax_pkg::SAMPLE_BITS'($urandom_range(6)) - 16'd3;
      2: ;                                  // repeat: flat stretch
      default: last_smp = swsax_pkg::SAMPLE_BITS'($urandom);
    endcase
    return last_smp;
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Extremes, samples before any series start, zero variance, empty segment.
  task automatic test_directed();
    gap_max   = 0;
    stall_pct = 0;
    set_geometry(4, 3, 3);  // third segment starts past the window: empty
    send_sample(16'h7FFF, 16'h1234, 1'b0);  // no series start yet: series 0
    send_sample(16'h8000, 16'h1234, 1'b0);
    send_sample(16'h7FFF, 16'h0000, 1'b0);
    send_sample(16'h8000, 16'h0000, 1'b0);
    send_sample(16'h0000, 16'h0000, 1'b0);
    send_sample(16'h0005, 16'hFFFF, 1'b1);  // new series clears the window
    repeat (4) send_sample(16'h0005, 16'hAAAA, 1'b0);  // flat: zero variance
    send_sample(16'hFFFF, 16'h5555, 1'b0);
    send_sample(16'h0001, 16'h5555, 1'b0);
    send_sample(16'h7FFF, 16'h5555, 1'b0);
    send_sample(16'h8000, 16'h5555, 1'b0);
    drain_words();
  endtask

  // Random phases over several geometries, extremes and clamped values too.
  task automatic test_random_phases();
    int unsigned cnt;
    logic        wide, first;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_geometry(256, 256, 15);                 // largest window
        1: set_geometry(2, 1, 15);                     // smallest, empty tails
        2: set_geometry(300, 0, 0);                    // all clamped
        3: set_geometry(0, 511, 15);
        default: set_geometry($urandom_range(24, 2), $urandom_range(8, 1),
                              $urandom_range(15));
      endcase
      gap_max   = (ph % 3 == 0) ? 0 : $urandom_range(20);
      stall_pct = (ph % 4 == 1) ? 0 : $urandom_range(70);
      // full-size windows need one long series to fill up
      wide = (ph == 0 || ph == 2);
      cnt  = wide ? 265 : 40;
      for (int i = 0; i < cnt; i++) begin
        first = wide ? 1'b0 : ($urandom_range(24) == 0);
        send_sample(pick_sample(), 16'($urandom), first);
      end
      drain_words();
    end
  endtask

  // Receiver holds off for a long time while samples keep coming.
  task automatic test_backpressure();
    set_geometry(6, 2, 3);
    gap_max   = 0;
    stall_pct = 10;
    hold_cycles = 800;
    for (int i = 0; i < 60; i++) send_sample(pick_sample(), 16'($urandom), (i == 0));
    drain_words();
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    samples_ch.valid <= 1'b0;
    samples_ch.sample <= '0;
    samples_ch.series_id <= '0;
    samples_ch.series_start <= 1'b0;
    ring_wr = 0; fill_shadow = 0; pos_shadow = 0; series_shadow = '0;
    win_len_reg   = swsax_pkg::RST_WINDOW_LEN;
    seg_width_reg = swsax_pkg::RST_SEGMENT_WIDTH;
    num_segs_reg  = swsax_pkg::RST_NUM_SEGMENTS;
    n_sent = 0; n_words = 0; n_errors = 0; n_zero_var = 0;
    stall_pct = 0; hold_cycles = 0; gap_max = 0; burst_left = 0; last_smp = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_phases();
    test_backpressure();

    $display("Sent %0d samples, checked %0d words (%0d flat windows).",
             n_sent, n_words, n_zero_var);
    $display("Geometries from 2 to 256 samples, clamped registers and long receiver stalls.");
    if (n_errors == 0 && pending_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d words missing", n_errors, pending_words.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
